FILE: hdl/cle_pkg.sv
// ---------------------------------------------------------------------------
// cle_pkg: shared types and constants for the cursor line editor
// Key codes, controller state type and controller/datapath bundles.
// ---------------------------------------------------------------------------
`default_nettype none

package cle_pkg;

  localparam int LINE_DEPTH_DEF = 64;

  localparam logic [7:0] KEY_UPPER_LO = 8'd65;   // 'A'
  localparam logic [7:0] KEY_UPPER_HI = 8'd90;   // 'Z'
  localparam logic [7:0] KEY_LOWER_LO = 8'd97;   // 'a'
  localparam logic [7:0] KEY_LOWER_HI = 8'd122;  // 'z'
  localparam logic [7:0] KEY_DIGIT_LO = 8'h30;   // '0'
  localparam logic [7:0] KEY_DIGIT_HI = 8'h39;   // '9'
  localparam logic [7:0] KEY_DELETE   = 8'h2D;   // '-'
  localparam logic [7:0] KEY_LEFT     = 8'h3C;   // '<'
  localparam logic [7:0] KEY_RIGHT    = 8'h3E;   // '>'

  localparam logic FUNC_KEY   = 1'b0;
  localparam logic FUNC_FLUSH = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOVE,
    ST_FL_RD,
    ST_FL_LD
  } cle_state_t;

  // controller -> datapath
  typedef struct packed {
    logic key_op;   // keystroke transaction accepted this cycle
    logic mv_wr;    // finish a cursor move: write the top read last cycle
    logic fl_rd;    // issue flush read of the current character
    logic fl_ld;    // load output register and advance flush index
  } cle_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic key_is_move;  // current key is a cursor move that takes effect
    logic out_free;     // output register can take a new result
    logic fl_last;      // current flush character is the last one
  } cle_stat_t;

endpackage

`default_nettype wire

FILE: hdl/cle_ram.sv
// ---------------------------------------------------------------------------
// cle_ram: generic single-port RAM
// One read or write per cycle; read data registered, held when not reading.
// ---------------------------------------------------------------------------
`default_nettype none

module cle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic                       re,
  input  wire logic [$clog2(DEPTH)-1:0]   addr,
  input  wire logic [WIDTH-1:0]           wdata,
  output logic      [WIDTH-1:0]           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/cle_ctrl.sv
// ---------------------------------------------------------------------------
// cle_ctrl: line editor controller
// Sequences keystrokes, two-step cursor moves and the flush walk.
// ---------------------------------------------------------------------------
`default_nettype none

module cle_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  input  wire logic                in_func,
  input  wire cle_pkg::cle_stat_t  stat,
  output cle_pkg::cle_cmd_t        cmd
);

  cle_pkg::cle_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cle_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_tready  = 1'b0;
    case (state_r)
      cle_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (in_func == cle_pkg::FUNC_FLUSH) begin
            state_nxt = cle_pkg::ST_FL_RD;
          end else begin
            cmd.key_op = 1'b1;
            if (stat.key_is_move) begin
              state_nxt = cle_pkg::ST_MOVE;
            end
          end
        end
      end
      cle_pkg::ST_MOVE: begin
        cmd.mv_wr = 1'b1;
        state_nxt = cle_pkg::ST_IDLE;
      end
      cle_pkg::ST_FL_RD: begin
        cmd.fl_rd = 1'b1;
        state_nxt = cle_pkg::ST_FL_LD;
      end
      cle_pkg::ST_FL_LD: begin
        if (stat.out_free) begin
          cmd.fl_ld = 1'b1;
          state_nxt = stat.fl_last ? cle_pkg::ST_IDLE : cle_pkg::ST_FL_RD;
        end
      end
      default: begin
        state_nxt = cle_pkg::ST_IDLE;
      end
    endcase
  end

  a_move_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == cle_pkg::ST_MOVE |=> state_r == cle_pkg::ST_IDLE)
    else $error("cursor move did not complete in one cycle");

  a_flush_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_func == cle_pkg::FUNC_FLUSH)
      |=> state_r == cle_pkg::ST_FL_RD)
    else $error("flush transaction did not start the flush walk");

  a_flush_end: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.fl_ld && stat.fl_last) |=> state_r == cle_pkg::ST_IDLE)
    else $error("controller did not return to idle after last character");

endmodule

`default_nettype wire

FILE: hdl/cle_dp.sv
// ---------------------------------------------------------------------------
// cle_dp: line editor datapath
// Left/right stack memories, counts, overflow flag, flush index and output
// register.
// ---------------------------------------------------------------------------
`default_nettype none

module cle_dp #(
  parameter int LINE_DEPTH = cle_pkg::LINE_DEPTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic [7:0]          in_tdata,
  input  wire cle_pkg::cle_cmd_t   cmd,
  output cle_pkg::cle_stat_t       stat,
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  output logic [7:0]               out_tdata,
  output logic                     out_tlast,
  output logic [1:0]               out_tuser
);

  localparam int AW = $clog2(LINE_DEPTH);
  localparam int CW = $clog2(LINE_DEPTH + 1);

  logic [CW-1:0] lc_r, lc_nxt, rc_r, rc_nxt, n_r, n_nxt;
  logic          ovf_r, ovf_nxt;
  logic          fsel_r, fsel_nxt;     // flush character comes from left stack
  logic          mvdir_r, mvdir_nxt;   // 1: move left top to right stack
  logic          ov_r, ov_nxt;         // output valid

  logic [7:0]    ch_r, ch_nxt;
  logic          last_r, last_nxt, empty_r, empty_nxt, ovfo_r, ovfo_nxt;

  logic [CW-1:0] total, rfl_addr, lc_dec, rc_dec;
  logic          is_ins, is_del, is_lt, is_gt;

  logic          l_we, l_re, r_we, r_re;
  logic [AW-1:0] l_addr, r_addr;
  logic [7:0]    l_wd, r_wd, l_q, r_q;

  assign total    = lc_r + rc_r;
  assign rfl_addr = total - CW'(1) - n_r;   // right stack is read top down
  assign lc_dec   = lc_r - CW'(1);
  assign rc_dec   = rc_r - CW'(1);

  always_comb begin
    is_ins = in_tdata inside {[cle_pkg::KEY_UPPER_LO : cle_pkg::KEY_UPPER_HI],
                              [cle_pkg::KEY_LOWER_LO : cle_pkg::KEY_LOWER_HI],
                              [cle_pkg::KEY_DIGIT_LO : cle_pkg::KEY_DIGIT_HI]};
    is_del = in_tdata == cle_pkg::KEY_DELETE;
    is_lt  = in_tdata == cle_pkg::KEY_LEFT;
    is_gt  = in_tdata == cle_pkg::KEY_RIGHT;
  end

  always_comb begin
    stat.key_is_move = (is_lt && lc_r != '0) || (is_gt && rc_r != '0);
    stat.out_free    = !ov_r || out_tready;
    stat.fl_last     = (total == '0) || (n_r + CW'(1) == total);
  end

  always_comb begin
    lc_nxt    = lc_r;
    rc_nxt    = rc_r;
    n_nxt     = n_r;
    ovf_nxt   = ovf_r;
    fsel_nxt  = fsel_r;
    mvdir_nxt = mvdir_r;
    ov_nxt    = ov_r;
    ch_nxt    = ch_r;
    last_nxt  = last_r;
    empty_nxt = empty_r;
    ovfo_nxt  = ovfo_r;
    l_we      = 1'b0;
    l_re      = 1'b0;
    r_we      = 1'b0;
    r_re      = 1'b0;
    l_addr    = n_r[AW-1:0];
    r_addr    = rfl_addr[AW-1:0];
    l_wd      = in_tdata;
    r_wd      = l_q;

    if (ov_r && out_tready) begin
      ov_nxt = 1'b0;
    end

    if (cmd.key_op) begin
      if (is_ins) begin
        if (total >= CW'(LINE_DEPTH)) begin
          ovf_nxt = 1'b1;
        end else begin
          l_we   = 1'b1;
          l_addr = lc_r[AW-1:0];
          lc_nxt = lc_r + CW'(1);
        end
      end else if (is_del) begin
        if (lc_r != '0) begin
          lc_nxt = lc_dec;
        end
      end else if (is_lt) begin
        if (lc_r != '0) begin
          l_re      = 1'b1;
          l_addr    = lc_dec[AW-1:0];
          mvdir_nxt = 1'b1;
        end
      end else if (is_gt) begin
        if (rc_r != '0) begin
          r_re      = 1'b1;
          r_addr    = rc_dec[AW-1:0];
          mvdir_nxt = 1'b0;
        end
      end
    end

    if (cmd.mv_wr) begin
      if (mvdir_r) begin
        r_we   = 1'b1;
        r_addr = rc_r[AW-1:0];
        r_wd   = l_q;
        lc_nxt = lc_dec;
        rc_nxt = rc_r + CW'(1);
      end else begin
        l_we   = 1'b1;
        l_addr = lc_r[AW-1:0];
        l_wd   = r_q;
        rc_nxt = rc_dec;
        lc_nxt = lc_r + CW'(1);
      end
    end

    if (cmd.fl_rd) begin
      l_re     = 1'b1;
      r_re     = 1'b1;
      fsel_nxt = n_r < lc_r;
    end

    if (cmd.fl_ld) begin
      ov_nxt    = 1'b1;
      empty_nxt = total == '0;
      ch_nxt    = (total == '0) ? 8'd0 : (fsel_r ? l_q : r_q);
      last_nxt  = stat.fl_last;
      ovfo_nxt  = ovf_r;
      if (stat.fl_last) begin
        lc_nxt  = '0;
        rc_nxt  = '0;
        n_nxt   = '0;
        ovf_nxt = 1'b0;
      end else begin
        n_nxt = n_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lc_r  <= '0;
      rc_r  <= '0;
      n_r   <= '0;
      ovf_r <= 1'b0;
      ov_r  <= 1'b0;
    end else begin
      lc_r  <= lc_nxt;
      rc_r  <= rc_nxt;
      n_r   <= n_nxt;
      ovf_r <= ovf_nxt;
      ov_r  <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fsel_r  <= fsel_nxt;
    mvdir_r <= mvdir_nxt;
    ch_r    <= ch_nxt;
    last_r  <= last_nxt;
    empty_r <= empty_nxt;
    ovfo_r  <= ovfo_nxt;
  end

  cle_ram #(.WIDTH(8), .DEPTH(LINE_DEPTH)) u_left (
    .clk   (clk),
    .we    (l_we),
    .re    (l_re),
    .addr  (l_addr),
    .wdata (l_wd),
    .rdata (l_q)
  );

  cle_ram #(.WIDTH(8), .DEPTH(LINE_DEPTH)) u_right (
    .clk   (clk),
    .we    (r_we),
    .re    (r_re),
    .addr  (r_addr),
    .wdata (r_wd),
    .rdata (r_q)
  );

  assign out_tvalid = ov_r;
  assign out_tdata  = ch_r;
  assign out_tlast  = last_r;
  assign out_tuser  = {ovfo_r, empty_r};

  a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
    total <= CW'(LINE_DEPTH))
    else $error("line buffer holds more than its depth");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fl_ld |-> (!ov_r || out_tready))
    else $error("output register overwritten before its transaction");

  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.fl_ld && stat.fl_last) |=> (lc_r == '0 && rc_r == '0 && !ovf_r))
    else $error("buffer not cleared after flush");

endmodule

`default_nettype wire

FILE: hdl/cursor_line_editor_core.sv
// ---------------------------------------------------------------------------
// cursor_line_editor_core: gap-buffer keystroke line editor
// Insert, delete and cursor moves on a line; end of line streams it out.
// ---------------------------------------------------------------------------
// Keystroke: insert, delete and ignored keys finish on acceptance; a cursor
//   move adds a write step after the registered read of the stack memory.
// End of line: each character is read from its stack (ST_FL_RD) and then
//   loaded into the output register (ST_FL_LD), waiting while the output is
//   not free; an empty line gives one result. Next input taken after the last.
// Reset: counts, overflow flag, controller and output valid cleared; the
//   stack memories are not cleared (entries are only read after a write).
`default_nettype none

module cursor_line_editor_core #(
  parameter int LINE_DEPTH = cle_pkg::LINE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] key
  input  wire logic        in_tuser,   // [0] func
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // [7:0] ch
  output logic             out_tlast,  // last
  output logic [1:0]       out_tuser   // [0] empty_line, [1] overflow
);

  cle_pkg::cle_cmd_t  cmd;
  cle_pkg::cle_stat_t stat;

  cle_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_func   (in_tuser),
    .stat      (stat),
    .cmd       (cmd)
  );

  cle_dp #(.LINE_DEPTH(LINE_DEPTH)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire

FILE: bench/cursor_line_editor_core_test.sv
// ---------------------------------------------------------------------------
// cursor_line_editor_core_test: self-checking bench for the line editor core
// Drives keystroke and end-of-line transactions with random gaps, predicts
// every emitted character from a gap-buffer model of the line and checks
// each output transaction field by field against the oldest expected one.
// ---------------------------------------------------------------------------
`default_nettype none

module cursor_line_editor_core_test;

  localparam int DEPTH        = cle_pkg::LINE_DEPTH_DEF;
  localparam int STALL_LIMIT  = 2000;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_ITEMS = 120;
  localparam int HOLD_AT      = 40;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       empty_line;
    logic       overflow;
  } line_char_t;

  class line_scoreboard;
    logic [7:0] left_chars [DEPTH];
    logic [7:0] right_chars [DEPTH];
    int         left_n = 0;
    int         right_n = 0;
    bit         dropped = 1'b0;
    line_char_t line_chars [$];
    int         errors = 0;

    static function bit is_text(logic [7:0] k);
      return (k >= cle_pkg::KEY_UPPER_LO && k <= cle_pkg::KEY_UPPER_HI) ||
             (k >= cle_pkg::KEY_LOWER_LO && k <= cle_pkg::KEY_LOWER_HI) ||
             (k >= cle_pkg::KEY_DIGIT_LO && k <= cle_pkg::KEY_DIGIT_HI);
    endfunction

    function void add_char(logic [7:0] ch, logic last, logic empty_line);
      line_char_t c;
      c.ch = ch;
      c.last = last;
      c.empty_line = empty_line;
      c.overflow = dropped;
      line_chars.push_back(c);
    endfunction

    // one accepted input transaction
    function void note_key(logic func, logic [7:0] key);
      int total;
      int n;
      int i;
      if (func == cle_pkg::FUNC_FLUSH) begin
        total = left_n + right_n;
        n = 0;
        if (total == 0) begin
          add_char(8'h00, 1'b1, 1'b1);
        end else begin
          // left stack bottom up, then right stack top down
          for (i = 0; i < left_n; i++) begin
            n++;
            add_char(left_chars[i], n == total, 1'b0);
          end
          for (i = right_n; i > 0; i--) begin
            n++;
            add_char(right_chars[i - 1], n == total, 1'b0);
          end
        end
        left_n = 0;
        right_n = 0;
        dropped = 1'b0;
      end else if (is_text(key)) begin
        if (left_n + right_n >= DEPTH) begin
          dropped = 1'b1;
        end else begin
          left_chars[left_n] = key;
          left_n++;
        end
      end else if (key == cle_pkg::KEY_DELETE) begin
        if (left_n > 0) left_n--;
      end else if (key == cle_pkg::KEY_LEFT) begin
        if (left_n > 0 && right_n < DEPTH) begin
          left_n--;
          right_chars[right_n] = left_chars[left_n];
          right_n++;
        end
      end else if (key == cle_pkg::KEY_RIGHT) begin
        if (right_n > 0 && left_n < DEPTH) begin
          right_n--;
          left_chars[left_n] = right_chars[right_n];
          left_n++;
        end
      end
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_char(line_char_t got);
      line_char_t want;
      if (line_chars.size() == 0) begin
        report($sformatf("unexpected transaction ch=%h last=%b empty=%b ovf=%b",
                         got.ch, got.last, got.empty_line, got.overflow));
        return;
      end
      want = line_chars.pop_front();
      if (got.ch !== want.ch)
        report($sformatf("ch %h, expected %h", got.ch, want.ch));
      if (got.last !== want.last)
        report($sformatf("last %b, expected %b (ch %h)", got.last, want.last, want.ch));
      if (got.empty_line !== want.empty_line)
        report($sformatf("empty_line %b, expected %b", got.empty_line, want.empty_line));
      if (got.overflow !== want.overflow)
        report($sformatf("overflow %b, expected %b", got.overflow, want.overflow));
    endtask

    function int pending();
      return line_chars.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;
  logic       in_tuser = cle_pkg::FUNC_KEY;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tlast;
  logic [1:0] out_tuser;

  line_scoreboard sb = new();
  int items_sent = 0;
  int idle_cycles = 0;
  bit hold_req = 1'b0;

  cursor_line_editor_core #(.LINE_DEPTH(DEPTH)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  // mostly no gap, some short, a few long
  function automatic int pick_gap();
    int r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] text_key();
    case ($urandom_range(0, 2))
      0:       return cle_pkg::KEY_UPPER_LO + 8'($urandom_range(0, 25));
      1:       return cle_pkg::KEY_LOWER_LO + 8'($urandom_range(0, 25));
      default: return cle_pkg::KEY_DIGIT_LO + 8'($urandom_range(0, 9));
    endcase
  endfunction

  function automatic logic [7:0] edit_key();
    int r = $urandom_range(0, 99);
    if (r < 50) return text_key();
    if (r < 65) return cle_pkg::KEY_DELETE;
    if (r < 80) return cle_pkg::KEY_LEFT;
    if (r < 92) return cle_pkg::KEY_RIGHT;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_item(logic func, logic [7:0] key);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= key;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_key(func, key);
    items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() > 0) @(posedge clk);
  endtask

  task automatic send_line(int keys, bit mostly_text);
    int i;
    for (i = 0; i < keys; i++)
      send_item(cle_pkg::FUNC_KEY,
                (mostly_text && $urandom_range(0, 9) != 0) ? text_key() : edit_key());
    send_item(cle_pkg::FUNC_FLUSH, 8'($urandom_range(0, 255)));
  endtask

  // fill past capacity, then edit around the full buffer
  task automatic fill_line();
    int i;
    for (i = 0; i < DEPTH + 4; i++) send_item(cle_pkg::FUNC_KEY, text_key());
    repeat (3) send_item(cle_pkg::FUNC_KEY, cle_pkg::KEY_LEFT);
    send_item(cle_pkg::FUNC_KEY, cle_pkg::KEY_DELETE);
    send_item(cle_pkg::FUNC_KEY, text_key());
    send_item(cle_pkg::FUNC_KEY, cle_pkg::KEY_RIGHT);
    send_item(cle_pkg::FUNC_FLUSH, 8'($urandom_range(0, 255)));
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_char({out_tdata, out_tlast, out_tuser[0], out_tuser[1]});
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side back-pressure
  initial begin
    int stall;
    repeat (11) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      stall = pick_gap();
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  initial begin
    logic [8:0] script [24];
    int i;
    int line_no;
    bit hold_done;
    script = '{
      {cle_pkg::FUNC_FLUSH, 8'hFF},
      {cle_pkg::FUNC_KEY, cle_pkg::KEY_DELETE}, {cle_pkg::FUNC_KEY, cle_pkg::KEY_LEFT},
      {cle_pkg::FUNC_KEY, cle_pkg::KEY_RIGHT},
      {cle_pkg::FUNC_KEY, 8'h00}, {cle_pkg::FUNC_KEY, 8'hFF},
      {cle_pkg::FUNC_KEY, 8'(cle_pkg::KEY_UPPER_LO - 8'd1)},
      {cle_pkg::FUNC_KEY, 8'(cle_pkg::KEY_UPPER_HI + 8'd1)},
      {cle_pkg::FUNC_KEY, 8'(cle_pkg::KEY_LOWER_LO - 8'd1)},
      {cle_pkg::FUNC_KEY, 8'(cle_pkg::KEY_LOWER_HI + 8'd1)},
      {cle_pkg::FUNC_KEY, 8'(cle_pkg::KEY_DIGIT_LO - 8'd1)},
      {cle_pkg::FUNC_KEY, 8'(cle_pkg::KEY_DIGIT_HI + 8'd1)},
      {cle_pkg::FUNC_KEY, cle_pkg::KEY_UPPER_LO}, {cle_pkg::FUNC_KEY, cle_pkg::KEY_UPPER_HI},
      {cle_pkg::FUNC_KEY, cle_pkg::KEY_LOWER_LO}, {cle_pkg::FUNC_KEY, cle_pkg::KEY_LOWER_HI},
      {cle_pkg::FUNC_KEY, cle_pkg::KEY_DIGIT_LO}, {cle_pkg::FUNC_KEY, cle_pkg::KEY_DIGIT_HI},
      {cle_pkg::FUNC_KEY, cle_pkg::KEY_LEFT}, {cle_pkg::FUNC_KEY, cle_pkg::KEY_LEFT},
      {cle_pkg::FUNC_KEY, cle_pkg::KEY_DELETE},
      {cle_pkg::FUNC_KEY, cle_pkg::KEY_RIGHT}, {cle_pkg::FUNC_KEY, cle_pkg::KEY_RIGHT},
      {cle_pkg::FUNC_FLUSH, 8'h00}
    };
    hold_done = 1'b0;
    line_no = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < 24; i++) send_item(script[i][8], script[i][7:0]);
    wait_drained();

    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if (line_no == 2) begin
        fill_line();
      end else if ($urandom_range(0, 19) == 0) begin
        send_line($urandom_range(40, 70), 1'b1);
      end else if ($urandom_range(0, 9) == 0) begin
        // noise: stray bytes and bare end-of-line transactions
        repeat ($urandom_range(1, 4))
          send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      end else begin
        send_line($urandom_range(0, 14), 1'b0);
      end
      if (!hold_done && items_sent >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_req = 1'b1;
      end
      line_no++;
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
